/* rtl/sam_pkg.sv */
// sam_pkg: shared constants and types for the sorted array merge block.
// No dependencies; imported by the channel interfaces and by sorted_array_merge.
package sam_pkg;

    // List capacity (1 to 32) and the widths derived from it
    localparam int DEPTH   = 32;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;

    // Input item kinds; the fourth code is ignored
    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

    typedef logic [KIND_W-1:0]         kind_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]          count_t;
    typedef logic [ADDR_W-1:0]         addr_t;

    typedef enum logic
    {
        S_IDLE,
        S_MERGE
    } state_t;

endpackage

/* rtl/sam_item_if.sv */
// sam_item_if: valid/ready channel carrying one input item (kind, value).
// Depends on sam_pkg.
interface sam_item_if;
    import sam_pkg::*;

    logic   valid;
    logic   ready;
    kind_t  kind;
    value_t value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

/* rtl/sam_result_if.sv */
// sam_result_if: valid/ready channel carrying one merged result item.
// Depends on sam_pkg.
interface sam_result_if;
    import sam_pkg::*;

    logic   valid;
    logic   ready;
    value_t value_res;
    logic   last;
    logic   overflow;

    modport source (output valid, output value_res, output last, output overflow, input ready);
    modport sink (input valid, input value_res, input last, input overflow, output ready);
endinterface

/* rtl/sorted_array_merge.sv */
// sorted_array_merge: loads two ascending lists into two list memories and emits their
// stable merge. Depends on sam_pkg, sam_item_if and sam_result_if.
//
// Usage: load items (kind A or B) are taken one per cycle while the block is idle and are
// written straight into the list memory at the list's fill count; a load into a full list
// is dropped and sets the overflow flag. After a start item the merge emits count_a +
// count_b elements in all, one per cycle while the result side does not stall.
// The rate is set by the single read port of each list memory:
// the next head of a list is read at the same edge that consumes the current one, so the
// compare always sees both heads registered. Item intake is closed while a merge runs.
// Ties go to list A. The final element carries last; every element of a merge carries
// overflow if a load was dropped since the previous merge. A start with both lists
// empty yields nothing. Each merge clears both counts and the flag. The result sits in an
// output register, so new loads are accepted while the last element waits to be taken.
// Memory contents are not reset; only entries below the fill counts are ever used.
module sorted_array_merge
(
    input  logic          clk,
    input  logic          rst_n,
    sam_item_if.sink      item,
    sam_result_if.source  result
);
    import sam_pkg::*;

    // List memories, one synchronous read port each
    value_t mem_a [DEPTH];
    value_t mem_b [DEPTH];
    value_t rd_a_reg;
    value_t rd_b_reg;

    state_t state_reg, state_next;
    count_t count_a_reg, count_a_next;
    count_t count_b_reg, count_b_next;
    logic   ovf_reg, ovf_next;
    count_t ia_reg, ia_next;   // read pointers; heads sit in rd_a_reg / rd_b_reg
    count_t ib_reg, ib_next;

    // Output register
    logic   out_valid_reg;
    value_t out_value_reg;
    logic   out_last_reg;
    logic   out_ovf_reg;

    logic             in_fire;
    logic             is_start;
    logic             we_a;
    logic             we_b;
    logic             emit;
    logic             a_left;
    logic             b_left;
    logic             take_a;
    logic             last_w;
    logic [CNT_W:0]   total;
    logic [CNT_W:0]   done_cnt;

    // ---------------- control decode ----------------
    assign in_fire  = item.valid && item.ready;
    assign is_start = in_fire && (item.kind == KIND_START);
    assign we_a     = in_fire && (item.kind == KIND_LOAD_A) && (count_a_reg < CNT_W'(DEPTH));
    assign we_b     = in_fire && (item.kind == KIND_LOAD_B) && (count_b_reg < CNT_W'(DEPTH));

    assign total    = {1'b0, count_a_reg} + {1'b0, count_b_reg};
    assign done_cnt = {1'b0, ia_reg} + {1'b0, ib_reg} + (CNT_W+1)'(1);
    assign last_w   = (done_cnt == total);

    // Merge step: output slot free or draining this cycle
    assign emit   = (state_reg == S_MERGE) && (!out_valid_reg || result.ready);
    assign a_left = (ia_reg < count_a_reg);
    assign b_left = (ib_reg < count_b_reg);
    assign take_a = a_left && (!b_left || (rd_a_reg <= rd_b_reg));

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (is_start && (total != '0))
                    state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (emit && last_w)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- outputs and datapath ----------------
    assign item.ready       = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.value_res = out_value_reg;
    assign result.last      = out_last_reg;
    assign result.overflow  = out_ovf_reg;

    always_comb
    begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        ovf_next     = ovf_reg;
        ia_next      = ia_reg;
        ib_next      = ib_reg;

        // Loads: append, or flag when full
        if (in_fire && (item.kind == KIND_LOAD_A))
        begin
            if (we_a)
                count_a_next = count_a_reg + CNT_W'(1);
            else
                ovf_next = 1'b1;
        end
        if (in_fire && (item.kind == KIND_LOAD_B))
        begin
            if (we_b)
                count_b_next = count_b_reg + CNT_W'(1);
            else
                ovf_next = 1'b1;
        end

        // Start with nothing loaded: just clear
        if (is_start && (total == '0))
        begin
            count_a_next = '0;
            count_b_next = '0;
            ovf_next     = 1'b0;
        end

        if (emit)
        begin
            if (last_w)
            begin
                count_a_next = '0;
                count_b_next = '0;
                ovf_next     = 1'b0;
                ia_next      = '0;
                ib_next      = '0;
            end
            else if (take_a)
                ia_next = ia_reg + CNT_W'(1);
            else
                ib_next = ib_reg + CNT_W'(1);
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            ovf_reg       <= 1'b0;
            ia_reg        <= '0;
            ib_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            ovf_reg     <= ovf_next;
            ia_reg      <= ia_next;
            ib_reg      <= ib_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= take_a ? rd_a_reg : rd_b_reg;
            out_last_reg  <= last_w;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // ---------------- list memories ----------------
    // Writes happen only while idle, reads matter only while merging, so a read never
    // overlaps a write to the same entry. Read address is the next pointer, so the new head
    // is registered at the same edge at which the pointer moves.
    always_ff @(posedge clk)
    begin
        if (we_a)
            mem_a[count_a_reg[ADDR_W-1:0]] <= item.value;
        rd_a_reg <= mem_a[ia_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            mem_b[count_b_reg[ADDR_W-1:0]] <= item.value;
        rd_b_reg <= mem_b[ib_next[ADDR_W-1:0]];
    end

`ifndef SYNTHESIS
    // The final element of a merge returns the block to idle with both lists cleared
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_w) |=> (state_reg == S_IDLE && count_a_reg == '0 && count_b_reg == '0))
        else $error("merge end did not clear state");

    // Read pointers never run past their fill counts during a merge
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> (ia_reg <= count_a_reg && ib_reg <= count_b_reg))
        else $error("read pointer past fill count");

    // A merge always has at least one element left to emit
    a_merge_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> (a_left || b_left))
        else $error("merge running with both lists exhausted");

    // A stalled result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !emit)
        else $error("result overwritten while stalled");
`endif

endmodule
